### rtl/adpcm_block_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// ADPCM block decoder assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ADPCM_BLOCK_DECODER_CORE_ASSERT_SVH
`define ADPCM_BLOCK_DECODER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Immediate-cycle implication under reset.
`define ABD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under reset.
`define ABD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ABD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ABD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/abd_pkg.sv
// ----------------------------------------------------------------------------
// ADPCM block decoder package
// Shared widths, queue word layout and predictor coefficient table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abd_pkg;

  localparam int SampleW   = 16;
  localparam int CoefW     = 8;
  localparam int ProdW     = SampleW + CoefW;
  localparam int CoefShift = 6;
  localparam int TermW     = ProdW - CoefShift;
  localparam int SumW      = TermW + 2;

  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = QueuePtrW + 1;

  localparam logic [3:0] PosHeader = 4'd0;
  localparam logic [3:0] PosFlags  = 4'd1;
  localparam logic [3:0] PosLast   = 4'd15;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] pred;
    logic [3:0] shift;
    logic [2:0] flags;
    logic       last;
    logic       clr;
  } abd_word_t;

  typedef struct packed {
    logic signed [CoefW-1:0] c0;
    logic signed [CoefW-1:0] c1;
  } abd_coef_t;

  function automatic abd_coef_t coef_lookup(input logic [2:0] pred);
    abd_coef_t c;
    case (pred)
      3'd1:    begin c.c0 = 8'sd60;  c.c1 = 8'sd0;   end
      3'd2:    begin c.c0 = 8'sd115; c.c1 = -8'sd52; end
      3'd3:    begin c.c0 = 8'sd98;  c.c1 = -8'sd55; end
      3'd4:    begin c.c0 = 8'sd122; c.c1 = -8'sd60; end
      default: begin c.c0 = 8'sd0;   c.c1 = 8'sd0;   end
    endcase
    return c;
  endfunction

endpackage

### rtl/abd_front.sv
// ----------------------------------------------------------------------------
// ADPCM block decoder front end
// Tracks the byte position, latches header fields and queues data bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              key_on_i,
  output logic              push_o,
  output abd_pkg::abd_word_t word_o
);

  logic [3:0] pos_q, pos_d, pos_eff;
  logic [2:0] pred_q, pred_d;
  logic [3:0] shift_q, shift_d;
  logic [2:0] flags_q, flags_d;
  logic       clr_q, clr_d;

  always_comb begin
    pos_eff = key_on_i ? abd_pkg::PosHeader : pos_q;
    pos_d   = pos_q;
    pred_d  = pred_q;
    shift_d = shift_q;
    flags_d = flags_q;
    clr_d   = clr_q;
    push_o  = 1'b0;
    if (accept_i) begin
      pos_d = pos_eff + 4'd1;
      if (pos_eff == abd_pkg::PosHeader) begin
        pred_d  = (data_byte_i[7:4] inside {[4'd0:4'd4]}) ? data_byte_i[6:4] : 3'd0;
        shift_d = data_byte_i[3:0];
      end else if (pos_eff == abd_pkg::PosFlags) begin
        flags_d = data_byte_i[2:0];
      end else begin
        push_o = 1'b1;
      end
      if (key_on_i) begin
        clr_d = 1'b1;
      end else if (push_o) begin
        clr_d = 1'b0;
      end
    end
  end

  always_comb begin
    word_o.data  = data_byte_i;
    word_o.pred  = pred_q;
    word_o.shift = shift_q;
    word_o.flags = flags_q;
    word_o.last  = (pos_eff == abd_pkg::PosLast);
    word_o.clr   = clr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      pred_q  <= '0;
      shift_q <= '0;
      flags_q <= '0;
      clr_q   <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      pred_q  <= pred_d;
      shift_q <= shift_d;
      flags_q <= flags_d;
      clr_q   <= clr_d;
    end
  end

endmodule

### rtl/abd_queue.sv
// ----------------------------------------------------------------------------
// ADPCM block decoder word queue
// Small register FIFO between the front end and the sample engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  abd_pkg::abd_word_t word_i,
  input  logic               pop_i,
  output abd_pkg::abd_word_t word_o,
  output logic               full_o,
  output logic               empty_o
);

  abd_pkg::abd_word_t mem_q [abd_pkg::QueueDepth];

  logic [abd_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [abd_pkg::QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == abd_pkg::QueueCntW'(abd_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign word_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/abd_back.sv
// ----------------------------------------------------------------------------
// ADPCM block decoder sample engine
// Decodes one nibble per fed, unstalled cycle against history; drives output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  abd_pkg::abd_word_t                  word_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [abd_pkg::SampleW-1:0]  sample_o,
  output logic                                loop_end_o,
  output logic                                loop_repeat_o,
  output logic                                loop_start_o,
  output logic                                block_last_o
);

  logic                               half_q, half_d;
  logic signed [abd_pkg::SampleW-1:0] hist_n_q, hist_n_d, hist_o_q, hist_o_d;
  logic signed [abd_pkg::SampleW-1:0] hn, ho, nib_val, nib_shr, smp;
  logic signed [abd_pkg::ProdW-1:0]   prod0, prod1;
  logic signed [abd_pkg::TermW-1:0]   term0, term1;
  logic signed [abd_pkg::SumW-1:0]    sum;
  logic [3:0]                         nib;
  logic                               load, valid_q, valid_d;
  abd_pkg::abd_coef_t                 coef;

  logic signed [abd_pkg::SampleW-1:0] sample_q;
  logic [2:0]                         flags_q;
  logic                               last_q;

  assign load  = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o = load && half_q;

  always_comb begin
    coef    = abd_pkg::coef_lookup(word_i.pred);
    nib     = half_q ? word_i.data[7:4] : word_i.data[3:0];
    hn      = (word_i.clr && !half_q) ? '0 : hist_n_q;
    ho      = (word_i.clr && !half_q) ? '0 : hist_o_q;
    nib_val = {nib, 12'b0};
    nib_shr = nib_val >>> word_i.shift;
    prod0   = abd_pkg::ProdW'(hn) * abd_pkg::ProdW'(coef.c0);
    prod1   = abd_pkg::ProdW'(ho) * abd_pkg::ProdW'(coef.c1);
    term0   = prod0[abd_pkg::ProdW-1:abd_pkg::CoefShift];
    term1   = prod1[abd_pkg::ProdW-1:abd_pkg::CoefShift];
    sum     = {{(abd_pkg::SumW-abd_pkg::SampleW){nib_shr[abd_pkg::SampleW-1]}}, nib_shr}
            + {{2{term0[abd_pkg::TermW-1]}}, term0}
            + {{2{term1[abd_pkg::TermW-1]}}, term1};
    if (sum > 20'sd32767) begin
      smp = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      smp = 16'sh8000;
    end else begin
      smp = sum[abd_pkg::SampleW-1:0];
    end
  end

  always_comb begin
    half_d   = half_q;
    hist_n_d = hist_n_q;
    hist_o_d = hist_o_q;
    valid_d  = valid_q;
    if (load) begin
      half_d   = !half_q;
      hist_o_d = hn;
      hist_n_d = smp;
      valid_d  = 1'b1;
    end else if (!out_stall_i) begin
      valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= 1'b0;
      hist_n_q <= '0;
      hist_o_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      half_q   <= half_d;
      hist_n_q <= hist_n_d;
      hist_o_q <= hist_o_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= smp;
      flags_q  <= word_i.flags;
      last_q   <= word_i.last && half_q;
    end
  end

  assign out_valid_o   = valid_q;
  assign sample_o      = sample_q;
  assign loop_end_o    = flags_q[0];
  assign loop_repeat_o = flags_q[1];
  assign loop_start_o  = flags_q[2];
  assign block_last_o  = last_q;

endmodule

### rtl/adpcm_block_decoder_core.sv
// ----------------------------------------------------------------------------
// ADPCM block decoder core
// Front end classifies stream bytes, a two-word queue feeds the sample engine.
// ----------------------------------------------------------------------------
// Flow: an accepted data byte is written into the queue; the sample engine
// then decodes its low nibble and then its high nibble into the output
// register, one sample per load. Header bytes produce no output and never
// enter the queue; data bytes can be accepted while the queue is not full.
// Reset: async active low, clears position, header fields, history, queue
// and output valid.
`timescale 1ns / 1ps
`include "adpcm_block_decoder_core_assert.svh"

module adpcm_block_decoder_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               key_on_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [abd_pkg::SampleW-1:0] sample_o,
  output logic                               loop_end_o,
  output logic                               loop_repeat_o,
  output logic                               loop_start_o,
  output logic                               block_last_o
);

  logic               accept, q_push, q_pop, q_full, q_empty;
  abd_pkg::abd_word_t q_wr_word, q_rd_word;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !in_stall_o;

  abd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .key_on_i    (key_on_i),
    .push_o      (q_push),
    .word_o      (q_wr_word)
  );

  abd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .word_i  (q_wr_word),
    .pop_i   (q_pop),
    .word_o  (q_rd_word),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  abd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .word_i        (q_rd_word),
    .empty_i       (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_o      (sample_o),
    .loop_end_o    (loop_end_o),
    .loop_repeat_o (loop_repeat_o),
    .loop_start_o  (loop_start_o),
    .block_last_o  (block_last_o)
  );

  `ABD_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, q_push, !q_full)
  `ABD_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, q_pop, !q_empty)
  `ABD_ASSERT_NOW(a_key_on_header, clk_i, rst_ni, accept && key_on_i, !q_push)
  `ABD_ASSERT_NEXT(a_pop_gives_out, clk_i, rst_ni, q_pop, out_valid_o)

endmodule
